### sv/s512c_pkg.sv
// Shared constants and SHA-512 bit functions for the block compression unit.
package s512c_pkg;

    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;

    typedef logic [63:0] t_word;

    // Initial hash value, word 0 first.
    localparam t_word IV_WORDS [HASH_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Round constants.
    localparam t_word ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // Rotations are by constants, so these are pure wiring and XOR.
    function automatic t_word big_sigma0(input t_word x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
    endfunction

endpackage

### sv/sha512_block_compress.sv
// SHA-512 block compression unit: word collection, round sequencer and hash word output.
//
// Usage: a 1024-bit padded block enters as sixteen 64-bit big-endian words on the
// input channel (i_valid / o_stall), word 0 first. Setting i_start_message on a word
// reloads the initial hash value and makes that word word 0 of a new block; a partial
// block in progress is dropped. Blocks sent without the flag chain from the current
// chaining value.
// After the sixteenth word the block runs the 80 rounds, one round per cycle on a single
// round datapath, then adds the working variables into the chaining value in an
// accumulation state. It then presents the eight chaining words on the output channel
// (o_valid / i_stall), most significant first, with o_word_index and o_last_word.
// The eight words then leave one per cycle while i_stall is low. No new block is taken
// until the last hash word of the current one has left, so the round loop sets the
// throughput. o_stall is high from the sixteenth word until the last hash word is
// taken. A stalled output word and its index hold steady until taken.
// Reset clears the sequencer and word count and loads the initial hash value.
module sha512_block_compress
    import s512c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_message_word,
    input  logic        i_start_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam int RND_W = $clog2(ROUNDS);
    localparam int CNT_W = $clog2(BLOCK_WORDS);
    localparam int IDX_W = $clog2(HASH_WORDS);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_WORDS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_WORDS - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [IDX_W-1:0] r_oidx, n_oidx;

    t_word r_cv [HASH_WORDS];
    t_word r_v  [HASH_WORDS];
    t_word r_w  [BLOCK_WORDS];

    logic  in_acc, out_acc, blk_done;
    t_word t1, t2, ch, maj, w_new;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign blk_done = in_acc && !i_start_message && (r_cnt == LAST_CNT);

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = (r_state == ST_OUT);
    assign o_hash_word  = r_cv[0];
    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == LAST_IDX);

    // Round datapath: one round per cycle, schedule word taken from the head of the line.
    always_comb begin
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_rnd] + r_w[0];
        t2    = big_sigma0(r_v[0]) + maj;
        w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_start_message) begin
                        n_cnt = CNT_W'(1);
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (blk_done) begin
                        n_state = ST_ROUND;
                        n_rnd   = '0;
                    end
                end
            end
            ST_ROUND: begin
                // The counter returns to zero after the last round so that it
                // always addresses a valid round constant.
                if (r_rnd == LAST_RND) begin
                    n_state = ST_ADD;
                    n_rnd   = '0;
                end else begin
                    n_rnd = r_rnd + RND_W'(1);
                end
            end
            ST_ADD: begin
                n_state = ST_OUT;
                n_oidx  = '0;
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + IDX_W'(1);
                    if (r_oidx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
        end
    end

    // Chaining value: reload on a start word, accumulate after the rounds, rotate on output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_cv[i] <= IV_WORDS[i];
            end
        end else if (in_acc && i_start_message) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_cv[i] <= IV_WORDS[i];
            end
        end else if (r_state == ST_ADD) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_cv[i] <= r_cv[i] + r_v[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
                r_cv[i] <= r_cv[i + 1];
            end
            r_cv[HASH_WORDS - 1] <= r_cv[0];
        end
    end

    // Message schedule line: words shift in at the tail, and each round consumes the
    // head and appends the expanded word sixteen places ahead.
    always_ff @(posedge i_clk) begin
        if (in_acc || (r_state == ST_ROUND)) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= in_acc ? i_message_word : w_new;
        end
    end

    // Working variables: loaded from the chaining value, then one round per cycle.
    always_ff @(posedge i_clk) begin
        if (blk_done) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_v[i] <= r_cv[i];
            end
        end else if (r_state == ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

`ifndef SYNTHESIS
    // The round counter never runs past the last round.
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd <= LAST_RND))
        else $error("round counter out of range");

    // Input is never taken while hash words are on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("input ready while output valid");

    // The sixteenth word of a block starts the rounds at round zero.
    a_start_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |=> (r_state == ST_ROUND) && (r_rnd == '0))
        else $error("block completion did not start the rounds");

    // Taking the last hash word frees the input side.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_word) |=> !o_stall && !o_valid)
        else $error("block not released after last hash word");

    // The accumulation state after the rounds is followed by output word zero.
    a_add_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> o_valid && (o_word_index == '0))
        else $error("accumulation not followed by first hash word");
`endif

endmodule
